[sv/bale_pkg.sv]
// bale_pkg: request codes, status codes and shared types of the array-list engine
// no dependencies
`timescale 1ns / 1ps
package bale_pkg;
    typedef enum logic [3:0] {
        REQ_APPEND  = 4'd0,
        REQ_INSERT  = 4'd1,
        REQ_DELETE  = 4'd2,
        REQ_LSEARCH = 4'd3,
        REQ_BSEARCH = 4'd4,
        REQ_GET     = 4'd5,
        REQ_SET     = 4'd6,
        REQ_MAX     = 4'd7,
        REQ_MIN     = 4'd8,
        REQ_SUM     = 4'd9,
        REQ_REVERSE = 4'd10,
        REQ_LSHIFT  = 4'd11,
        REQ_LROT    = 4'd12,
        REQ_RROT    = 4'd13,
        REQ_RSVD14  = 4'd14,
        REQ_RSVD15  = 4'd15
    } t_req;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD  = 3'd0,
        CELL_UP    = 3'd1,  // take left neighbor
        CELL_DOWN  = 3'd2,  // take right neighbor
        CELL_LOAD  = 3'd3,  // take broadcast value
        CELL_SWAP  = 3'd4   // take mirror word
    } t_cell_op;

    typedef struct packed {
        t_cell_op     op;
        logic [31:0]  wdata;
    } t_cell_ctl;
endpackage

[sv/bale_if.sv]
// bale_req_if / bale_rsp_if: valid-ready channels of the array-list engine
// no dependencies
`timescale 1ns / 1ps
interface bale_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         req_type;
    logic [4:0]         index;
    logic signed [31:0] value;
    logic signed [31:0] key;
    logic [4:0]         search_low;
    logic signed [4:0]  search_high;
    modport source (output valid, req_type, index, value, key, search_low, search_high,
                    input ready);
    modport sink   (input valid, req_type, index, value, key, search_low, search_high,
                    output ready);
endinterface

interface bale_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [4:0]  found_index;
    logic signed [31:0] data;
    logic signed [35:0] total;
    logic [4:0]         length_now;
    modport source (output valid, status, found_index, data, total, length_now,
                    input ready);
    modport sink   (input valid, status, found_index, data, total, length_now,
                    output ready);
endinterface

[sv/bale_cell.sv]
// bale_cell: one element slot of the store chain
// depends on bale_pkg
`timescale 1ns / 1ps
module bale_cell
    import bale_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_cell_ctl   i_ctl,
    input  logic [31:0] i_left,
    input  logic [31:0] i_right,
    input  logic [31:0] i_mirror,
    output logic [31:0] o_word
);
    logic [31:0] r_word;
    logic [31:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_en) begin
            case (i_ctl.op)
                CELL_UP:   n_word = i_left;
                CELL_DOWN: n_word = i_right;
                CELL_LOAD: n_word = i_ctl.wdata;
                CELL_SWAP: n_word = i_mirror;
                default:   n_word = r_word;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
endmodule

[sv/bounded_array_list_engine.sv]
// bounded_array_list_engine: array-list store built from a chain of element cells
// depends on bale_pkg, bale_if, bale_cell
//
//  channel   dir   handshake     payload
//  req       in    valid/ready   req_type index value key search_low search_high
//  rsp       out   valid/ready   status found_index data total length_now
//  cfg       in    i_cfg_we      i_cfg_wdata (max_length)
//
// one request at a time; every request is accepted and then answered with one response word
// append/get/set act on one cell at accept, and delete/shift move the chain down at accept;
// insert and rotate load the placed word in the following cycle
// sum, linear search, max and min walk one cell a cycle;
// reverse swaps one pair a cycle; binary search halves its bounds each step
// reset (synchronous, active low) clears fill count and control; cell words are
// undefined until written; a stalled response holds and blocks the next request
`timescale 1ns / 1ps
module bounded_array_list_engine
    import bale_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bale_req_if.sink   req,
    bale_rsp_if.source rsp,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    // binary search bounds hold search_low (up to 31) and twice the top index
    localparam int SW = (IW + 2 > 6) ? IW + 2 : 6;
    localparam logic signed [SW-1:0] ONE_S = SW'(1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_BIN, S_DONE} t_state;

    t_state                r_state;
    logic [4:0]            r_max_len;
    logic [CW-1:0]         r_fill;
    t_req                  r_req;
    logic [31:0]           r_key;
    logic [IW:0]           r_ptr;   // walk pointer (a side)
    logic [IW:0]           r_ptr_b; // mirror pointer for reverse
    logic signed [SW-1:0]  r_lo;
    logic signed [SW-1:0]  r_hi;
    logic [31:0]           r_acc;
    logic signed [35:0]    r_sum;
    logic                  r_found;
    logic [IW:0]           r_found_ix;

    logic [2:0]            r_status;
    logic signed [4:0]     r_found_o;
    logic signed [31:0]    r_data_o;
    logic signed [35:0]    r_total_o;

    // rotate and insert place one word in the cycle after the shift
    logic                  r_wrap;
    logic [31:0]           r_wrap_data;
    logic [IW-1:0]         r_wrap_ix;

    // cell chain
    logic [31:0]   w_word [CAPACITY];
    logic          w_en   [CAPACITY];
    t_cell_ctl     w_ctl;

    // chain read port for the walking operations and the binary search
    logic [IW-1:0] w_rd_ix;
    logic [31:0]   w_rd;
    logic [31:0]   w_rd_b;
    assign w_rd   = w_word[w_rd_ix];
    assign w_rd_b = w_word[r_ptr_b[IW-1:0]];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [31:0] w_left, w_right, w_mirror;
            if (g == 0) begin : g_l0
                assign w_left = w_word[0];
            end else begin : g_ln
                assign w_left = w_word[g-1];
            end
            if (g == CAPACITY - 1) begin : g_rn
                assign w_right = w_word[g];
            end else begin : g_r
                assign w_right = w_word[g+1];
            end
            // reverse swaps the a/b pair: cell a takes b, cell b takes a
            assign w_mirror = (r_ptr[IW-1:0] == IW'(g)) ? w_rd_b : w_rd;
            bale_cell u_cell (
                .i_clk    (i_clk),
                .i_en     (w_en[g]),
                .i_ctl    (w_ctl),
                .i_left   (w_left),
                .i_right  (w_right),
                .i_mirror (w_mirror),
                .o_word   (w_word[g])
            );
        end
    endgenerate

    // request decode on acceptance
    logic             w_acc;
    t_req             w_rq;
    logic [CW-1:0]    w_limit;
    logic [IW:0]      w_ix;
    logic             w_empty;
    logic             w_needs;
    logic signed [SW-1:0] w_shi;
    logic signed [SW-1:0] w_top;
    logic signed [SW-1:0] w_hi_clip;
    logic signed [SW-1:0] w_mid;

    assign w_acc   = req.valid && req.ready;
    assign w_rq    = t_req'(req.req_type);
    assign w_ix    = (IW + 1 >= 5) ? (IW+1)'(req.index) : (IW+1)'(req.index);
    assign w_empty = (r_fill == '0);
    assign w_limit = ({27'd0, r_max_len} < 32'(CAPACITY)) ? CW'(r_max_len) : CW'(CAPACITY);
    assign w_needs = (w_rq == REQ_DELETE) || (w_rq == REQ_GET) || (w_rq == REQ_SET)
                  || (w_rq == REQ_MAX) || (w_rq == REQ_MIN) || (w_rq == REQ_LSHIFT)
                  || (w_rq == REQ_LROT) || (w_rq == REQ_RROT);
    // high end clipped to the last held position, -1 when empty
    assign w_shi     = SW'(req.search_high);
    assign w_top     = $signed(SW'(r_fill) - SW'(1));
    assign w_hi_clip = (w_shi > w_top) ? w_top : w_shi;
    assign w_mid     = (r_lo + r_hi) >>> 1;

    logic             w_idx_ok_ins;
    logic             w_idx_ok;
    logic             w_room;
    logic [CW-1:0]    w_fill_m1;
    assign w_idx_ok_ins = {27'd0, req.index} <= 32'(r_fill);
    assign w_idx_ok     = {27'd0, req.index} <  32'(r_fill);
    assign w_room       = r_fill < w_limit;
    assign w_fill_m1    = r_fill - CW'(1);

    always_comb begin
        w_ctl.op    = CELL_HOLD;
        w_ctl.wdata = req.value;
        for (int k = 0; k < CAPACITY; k++) w_en[k] = 1'b0;
        w_rd_ix = r_ptr[IW-1:0];
        if (r_state == S_BIN) w_rd_ix = w_mid[IW-1:0];
        if (r_state == S_IDLE && w_acc && !(w_needs && w_empty)) begin
            unique case (w_rq)
                REQ_APPEND: if (w_room) begin
                    w_ctl.op = CELL_LOAD;
                    for (int k = 0; k < CAPACITY; k++) w_en[k] = (CW'(k) == r_fill);
                end
                REQ_INSERT: if (w_idx_ok_ins && w_room) begin
                    for (int k = 0; k < CAPACITY; k++) begin
                        w_en[k] = (CW'(k) >= CW'(w_ix)) && (CW'(k) <= r_fill);
                    end
                    w_ctl.op = CELL_UP;
                end
                REQ_DELETE, REQ_LSHIFT: begin
                    w_ctl.op = CELL_DOWN;
                    for (int k = 0; k < CAPACITY; k++) begin
                        w_en[k] = (w_rq == REQ_LSHIFT || CW'(k) >= CW'(w_ix))
                               && (CW'(k) + CW'(1) < r_fill);
                    end
                    if (w_rq == REQ_DELETE && !w_idx_ok)
                        for (int k = 0; k < CAPACITY; k++) w_en[k] = 1'b0;
                end
                REQ_SET: if (w_idx_ok) begin
                    w_ctl.op = CELL_LOAD;
                    for (int k = 0; k < CAPACITY; k++) w_en[k] = (CW'(k) == CW'(w_ix));
                end
                REQ_LROT: begin
                    w_ctl.op = CELL_DOWN;
                    for (int k = 0; k < CAPACITY; k++) w_en[k] = CW'(k) + CW'(1) < r_fill;
                end
                REQ_RROT: begin
                    w_ctl.op = CELL_UP;
                    for (int k = 1; k < CAPACITY; k++) w_en[k] = CW'(k) < r_fill;
                end
                default: ;
            endcase
        end else if (r_wrap) begin
            // place the wrapped or inserted word
            w_ctl.op    = CELL_LOAD;
            w_ctl.wdata = r_wrap_data;
            for (int k = 0; k < CAPACITY; k++) w_en[k] = (r_wrap_ix == IW'(k));
        end else if (r_state == S_WALK && r_req == REQ_REVERSE && r_ptr < r_ptr_b) begin
            w_ctl.op = CELL_SWAP;
            for (int k = 0; k < CAPACITY; k++)
                w_en[k] = (r_ptr[IW-1:0] == IW'(k)) || (r_ptr_b[IW-1:0] == IW'(k));
        end
    end

    assign req.ready = (r_state == S_IDLE) && !r_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_max_len <= 5'd16;
            r_fill    <= '0;
            r_wrap    <= 1'b0;
        end else begin
            if (i_cfg_we) r_max_len <= i_cfg_wdata;
            r_wrap <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_acc) begin
                    r_req     <= w_rq;
                    r_key     <= req.key;
                    r_status  <= ST_OK;
                    r_found_o <= -5'sd1;
                    r_data_o  <= '0;
                    r_total_o <= '0;
                    r_sum     <= '0;
                    r_found   <= 1'b0;
                    r_ptr     <= '0;
                    r_ptr_b   <= w_empty ? '0 : (IW+1)'(w_fill_m1);
                    r_state   <= S_DONE;
                    if (w_needs && w_empty) begin
                        r_status <= ST_EMPTY;
                    end else begin
                        unique case (w_rq)
                            REQ_APPEND: if (w_room) r_fill <= r_fill + CW'(1);
                                        else r_status <= ST_FULL;
                            REQ_INSERT: if (!w_idx_ok_ins) r_status <= ST_RANGE;
                                else if (!w_room) r_status <= ST_FULL;
                                else begin
                                    r_fill      <= r_fill + CW'(1);
                                    r_wrap      <= 1'b1;
                                    r_wrap_ix   <= w_ix[IW-1:0];
                                    r_wrap_data <= req.value;
                                end
                            REQ_DELETE: if (!w_idx_ok) r_status <= ST_RANGE;
                                        else r_fill <= w_fill_m1;
                            REQ_LSHIFT: r_fill <= w_fill_m1;
                            REQ_GET: if (!w_idx_ok) r_status <= ST_RANGE;
                                     else r_data_o <= w_word[w_ix[IW-1:0]];
                            REQ_SET: if (!w_idx_ok) r_status <= ST_RANGE;
                            REQ_LROT: begin
                                r_wrap      <= 1'b1;
                                r_wrap_ix   <= w_fill_m1[IW-1:0];
                                r_wrap_data <= w_word[0];
                            end
                            REQ_RROT: begin
                                r_wrap      <= 1'b1;
                                r_wrap_ix   <= '0;
                                r_wrap_data <= w_word[w_fill_m1[IW-1:0]];
                            end
                            REQ_LSEARCH, REQ_SUM, REQ_REVERSE: r_state <= S_WALK;
                            REQ_MAX, REQ_MIN: begin
                                r_acc   <= w_word[0];
                                r_ptr   <= (IW+1)'(1);
                                r_state <= S_WALK;
                            end
                            REQ_BSEARCH: begin
                                r_lo    <= SW'(req.search_low);
                                r_hi    <= w_hi_clip;
                                r_state <= S_BIN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK: begin
                    if (r_req == REQ_REVERSE) begin
                        if (r_ptr < r_ptr_b) begin
                            r_ptr   <= r_ptr + 1'b1;
                            r_ptr_b <= r_ptr_b - 1'b1;
                        end else r_state <= S_DONE;
                    end else if (CW'(r_ptr) >= r_fill || r_found) begin
                        r_state <= S_DONE;
                        case (r_req)
                            REQ_SUM: r_total_o <= r_sum;
                            REQ_MAX, REQ_MIN: r_data_o <= r_acc;
                            default: if (r_found) r_found_o <= 5'(r_found_ix);
                                     else r_status <= ST_NOTFOUND;
                        endcase
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                        case (r_req)
                            REQ_SUM: r_sum <= r_sum + 36'($signed(w_rd));
                            REQ_MAX: if ($signed(w_rd) > $signed(r_acc)) r_acc <= w_rd;
                            REQ_MIN: if ($signed(w_rd) < $signed(r_acc)) r_acc <= w_rd;
                            default: if (w_rd == r_key) begin
                                r_found    <= 1'b1;
                                r_found_ix <= r_ptr;
                            end
                        endcase
                    end
                end
                S_BIN: begin
                    if (r_lo > r_hi) begin
                        r_status <= ST_NOTFOUND;
                        r_state  <= S_DONE;
                    end else if (w_rd == r_key) begin
                        r_found_o <= 5'(w_mid);
                        r_state   <= S_DONE;
                    end else if ($signed(r_key) > $signed(w_rd)) r_lo <= w_mid + ONE_S;
                    else r_hi <= w_mid - ONE_S;
                end
                S_DONE: if (rsp.valid && rsp.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid       = (r_state == S_DONE) && !r_wrap;
    assign rsp.status      = r_status;
    assign rsp.found_index = r_found_o;
    assign rsp.data        = r_data_o;
    assign rsp.total       = r_total_o;
    assign rsp.length_now  = 5'(r_fill);

    unused_fix_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wrap |-> r_state == S_DONE)
        else $error("fixup write outside done state");
    fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= CAPACITY)
        else $error("fill count above capacity");
    one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
        else $error("response dropped while stalled");
endmodule

[dv/bounded_array_list_engine_tb.sv]
// bounded_array_list_engine_tb: directed and random request streams against a scoreboard
// depends on bale_pkg, bale_if and the bounded_array_list_engine rtl
`timescale 1ns / 1ps
module bounded_array_list_engine_tb;
    import bale_pkg::*;

    localparam int CAP        = 16;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [4:0]  found_index;
        logic signed [31:0] data;
        logic signed [35:0] total;
        logic [4:0]         length_now;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [4:0] i_cfg_wdata = '0;

    bale_req_if req ();
    bale_rsp_if rsp ();

    bounded_array_list_engine #(.CAPACITY(CAP)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req        (req),
        .rsp        (rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the engine state
    logic signed [31:0] shadow_store [CAP];
    int                 shadow_fill;
    int                 shadow_limit;
    t_answer            pending_answers [$];
    int                 mismatch_count = 0;
    int                 answers_seen = 0;
    int                 idle_cycles = 0;
    int                 rsp_hold = 0;
    bit                 rsp_stall_on = 1'b1;

    initial begin
        req.valid = 1'b0;
        req.req_type = '0;
        req.index = '0;
        req.value = '0;
        req.key = '0;
        req.search_low = '0;
        req.search_high = '0;
        rsp.ready = 1'b0;
    end

    // works out the answer for one request and updates the shadow
    function automatic t_answer predict_answer(t_req op, logic [4:0] idx,
                                               logic signed [31:0] val,
                                               logic signed [31:0] key,
                                               logic [4:0] slo,
                                               logic signed [4:0] shi);
        t_answer a;
        int n;
        int lo;
        int hi;
        int mid;
        logic signed [31:0] w;
        logic signed [63:0] acc;
        bit needs;
        a.status = ST_OK;
        a.found_index = -5'sd1;
        a.data = '0;
        a.total = '0;
        n = shadow_fill;
        acc = 0;
        needs = op inside {REQ_DELETE, REQ_GET, REQ_SET, REQ_MAX, REQ_MIN,
                           REQ_LSHIFT, REQ_LROT, REQ_RROT};
        if (needs && n == 0) begin
            a.status = ST_EMPTY;
        end else begin
            case (op)
                REQ_APPEND: begin
                    if (n < shadow_limit && n < CAP) begin
                        shadow_store[n] = val;
                        shadow_fill = n + 1;
                    end else a.status = ST_FULL;
                end
                REQ_INSERT: begin
                    if (idx > n) a.status = ST_RANGE;
                    else if (n >= shadow_limit || n >= CAP) a.status = ST_FULL;
                    else begin
                        for (int i = n; i > idx; i--) shadow_store[i] = shadow_store[i-1];
                        shadow_store[idx] = val;
                        shadow_fill = n + 1;
                    end
                end
                REQ_DELETE: begin
                    if (idx >= n) a.status = ST_RANGE;
                    else begin
                        for (int i = idx; i + 1 < n; i++) shadow_store[i] = shadow_store[i+1];
                        shadow_fill = n - 1;
                    end
                end
                REQ_LSEARCH: begin
                    for (int i = 0; i < n; i++) begin
                        if (shadow_store[i] == key && a.found_index < 0) a.found_index = i;
                    end
                    if (a.found_index < 0) a.status = ST_NOTFOUND;
                end
                REQ_BSEARCH: begin
                    lo = slo;
                    hi = shi;
                    if (hi > n - 1) hi = n - 1;
                    while (lo <= hi) begin
                        mid = (lo + hi) / 2;
                        w = shadow_store[mid];
                        if (w == key) begin
                            a.found_index = mid;
                            break;
                        end else if (key > w) lo = mid + 1;
                        else hi = mid - 1;
                    end
                    if (a.found_index < 0) a.status = ST_NOTFOUND;
                end
                REQ_GET: begin
                    if (idx >= n) a.status = ST_RANGE;
                    else a.data = shadow_store[idx];
                end
                REQ_SET: begin
                    if (idx >= n) a.status = ST_RANGE;
                    else shadow_store[idx] = val;
                end
                REQ_MAX, REQ_MIN: begin
                    a.data = shadow_store[0];
                    for (int i = 1; i < n; i++) begin
                        w = shadow_store[i];
                        if (op == REQ_MAX ? (w > a.data) : (w < a.data)) a.data = w;
                    end
                end
                REQ_SUM: begin
                    for (int i = 0; i < n; i++) acc += shadow_store[i];
                    a.total = acc[35:0];
                end
                REQ_REVERSE: begin
                    for (int i = 0; i < n / 2; i++) begin
                        w = shadow_store[i];
                        shadow_store[i] = shadow_store[n-1-i];
                        shadow_store[n-1-i] = w;
                    end
                end
                REQ_LSHIFT: begin
                    for (int i = 0; i + 1 < n; i++) shadow_store[i] = shadow_store[i+1];
                    shadow_fill = n - 1;
                end
                REQ_LROT: begin
                    w = shadow_store[0];
                    for (int i = 0; i + 1 < n; i++) shadow_store[i] = shadow_store[i+1];
                    shadow_store[n-1] = w;
                end
                REQ_RROT: begin
                    w = shadow_store[n-1];
                    for (int i = n - 1; i > 0; i--) shadow_store[i] = shadow_store[i-1];
                    shadow_store[0] = w;
                end
                default: ;
            endcase
        end
        a.length_now = shadow_fill[4:0];
        return a;
    endfunction

    // sends one request word after a random gap and records its answer
    // valid stays high after the handshake so a zero gap can follow directly
    task automatic send_request(t_req op, logic [4:0] idx, logic signed [31:0] val,
                                logic signed [31:0] key, logic [4:0] slo,
                                logic signed [4:0] shi);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.req_type <= op;
        req.index <= idx;
        req.value <= val;
        req.key <= key;
        req.search_low <= slo;
        req.search_high <= shi;
        do @(posedge i_clk); while (!(req.valid && req.ready));
        pending_answers.push_back(predict_answer(op, idx, val, key, slo, shi));
    endtask

    // drain, then write the limit register while the engine is idle
    task automatic set_limit(logic [4:0] lim);
        req.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_limit = lim;
    endtask

    // a random value that often hits the extremes or small numbers
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 8)) - 4;
            default: return $signed($urandom());
        endcase
    endfunction

    // pick a live index mostly; sometimes one past or far outside
    function automatic logic [4:0] pick_index(int extra);
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 31);
        return $urandom_range(0, shadow_fill + extra > 0 ? shadow_fill + extra - 1 : 0);
    endfunction

    // random request that never reads an unwritten cell
    task automatic send_random();
        t_req op;
        logic signed [31:0] key;
        op = t_req'($urandom_range(0, 15));
        if (shadow_fill < 4 && $urandom_range(0, 1)) op = REQ_APPEND;
        key = (shadow_fill > 0 && $urandom_range(0, 1)) ?
              shadow_store[$urandom_range(0, shadow_fill - 1)] : pick_value();
        send_request(op, pick_index(op == REQ_INSERT ? 1 : 0), pick_value(), key,
                     $urandom_range(0, 31), $signed(5'($urandom_range(0, 31))));
    endtask

    task automatic test_directed_extremes();
        send_request(REQ_MAX, 0, 0, 0, 0, 0);
        send_request(REQ_SUM, 0, 0, 0, 0, 0);
        send_request(REQ_REVERSE, 0, 0, 0, 0, 0);
        send_request(REQ_LSEARCH, 0, 0, 5, 0, 0);
        send_request(REQ_BSEARCH, 0, 0, 5, 0, 15);
        send_request(REQ_INSERT, 1, 7, 0, 0, 0);
        send_request(REQ_INSERT, 0, 32'sh80000000, 0, 0, 0);
        send_request(REQ_APPEND, 0, 32'sh7fffffff, 0, 0, 0);
        send_request(REQ_APPEND, 31, -1, 0, 31, -1);
        send_request(REQ_GET, 5'd3, 0, 0, 0, 0);
        send_request(REQ_SET, 1, 42, 0, 0, 0);
        send_request(REQ_LSEARCH, 0, 0, 42, 0, 0);
        send_request(REQ_MIN, 0, 0, 0, 0, 0);
        send_request(REQ_SUM, 0, 0, 0, 0, 0);
        send_request(REQ_RROT, 0, 0, 0, 0, 0);
        send_request(REQ_LROT, 0, 0, 0, 0, 0);
        send_request(REQ_REVERSE, 0, 0, 0, 0, 0);
        send_request(REQ_RSVD14, 5'h1f, -1, -1, 5'h1f, -1);
        send_request(REQ_RSVD15, 0, 0, 0, 0, 0);
        send_request(REQ_DELETE, 0, 0, 0, 0, 0);
        send_request(REQ_LSHIFT, 0, 0, 0, 0, 0);
        send_request(REQ_DELETE, 5, 0, 0, 0, 0);
    endtask

    // fill with a sorted list and probe with binary searches
    task automatic test_sorted_search(int count);
        logic signed [31:0] base;
        for (int r = 0; r < count; r++) begin
            while (shadow_fill > 0) send_request(REQ_LSHIFT, 0, 0, 0, 0, 0);
            base = $signed($urandom()) >>> 2;
            for (int i = 0; i < shadow_limit && i < CAP; i++) begin
                send_request(REQ_APPEND, 0, base, 0, 0, 0);
                base = base + $signed(32'($urandom_range(1, 9)));
            end
            send_request(REQ_APPEND, 0, 1, 0, 0, 0);  // full check
            for (int k = 0; k < 6; k++)
                send_request(REQ_BSEARCH, 0, 0,
                             shadow_fill > 0 && $urandom_range(0, 3) != 0 ?
                             shadow_store[$urandom_range(0, shadow_fill - 1)] : pick_value(),
                             $urandom_range(0, 17), $signed(5'($urandom_range(0, 31))));
        end
    endtask

    task automatic test_random_mix(int count);
        for (int i = 0; i < count; i++) send_random();
    endtask

    // response side: drawn stall, then compare against the oldest expectation
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected answer status=%0d", $time, rsp.status);
                mismatch_count++;
            end else begin
                want = pending_answers.pop_front();
                if (want.status !== rsp.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, rsp.status);
                    mismatch_count++;
                end
                if (want.found_index !== rsp.found_index) begin
                    $display("%0t: found_index exp %0d got %0d", $time,
                             want.found_index, rsp.found_index);
                    mismatch_count++;
                end
                if (want.data !== rsp.data) begin
                    $display("%0t: data exp %0d got %0d", $time, want.data, rsp.data);
                    mismatch_count++;
                end
                if (want.total !== rsp.total) begin
                    $display("%0t: total exp %0d got %0d", $time, want.total, rsp.total);
                    mismatch_count++;
                end
                if (want.length_now !== rsp.length_now) begin
                    $display("%0t: length_now exp %0d got %0d", $time,
                             want.length_now, rsp.length_now);
                    mismatch_count++;
                end
            end
        end
        // each word waits a drawn number of cycles before ready, none in quiet runs
        if (!i_rst_n) begin
            rsp_hold = 0;
            rsp.ready <= 1'b0;
        end else begin
            if (rsp.valid && rsp.ready) rsp_hold = rsp_stall_on ? $urandom_range(0, 14) : 0;
            else if (rsp.valid && rsp_hold > 0) rsp_hold--;
            rsp.ready <= (rsp_hold == 0);
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < CAP; i++) shadow_store[i] = '0;
        shadow_fill = 0;
        shadow_limit = 16;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_sorted_search(3);
        test_random_mix(400);
        set_limit(5'd0);
        test_random_mix(60);
        set_limit(5'd3);
        test_sorted_search(2);
        test_random_mix(250);
        set_limit(5'd31);
        rsp_stall_on = 1'b0;
        test_random_mix(300);
        rsp_stall_on = 1'b1;
        set_limit(5'd9);
        test_random_mix(300);
        set_limit(5'd16);
        test_sorted_search(4);
        test_random_mix(300);
        req.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("covered all request kinds at limits 0, 3, 9, 16 and 31; %0d answers checked",
                 answers_seen);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

[sim.f]
sv/bale_pkg.sv
sv/bale_if.sv
sv/bale_cell.sv
sv/bounded_array_list_engine.sv
dv/bounded_array_list_engine_tb.sv
